/* rtl/alm_pkg.sv */
// alm_pkg: shared types, constants and weight/reciprocal/log tables for the lse merge block
`timescale 1ns / 1ps

package alm_pkg;

    localparam int EXP_TABLE_DEPTH = 64;
    localparam int LOG_TABLE_DEPTH = 64;
    localparam int CODE_W          = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int QUEUE_DEPTH     = 4;
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // one input beat
    typedef struct packed {
        logic               first_of_position;
        logic signed [23:0] lse_a;
        logic signed [23:0] lse_b;
        logic signed [15:0] value_a;
        logic signed [15:0] value_b;
    } item_t;

    // one result beat
    typedef struct packed {
        logic signed [15:0] merged_value;
        logic signed [23:0] merged_lse;
        logic               lse_valid;
    } result_t;

    // classified element handed from front to back
    typedef struct packed {
        logic [16:0]        weight_a;
        logic [16:0]        weight_b;
        logic [16:0]        inverse_sum;
        logic signed [23:0] merged_lse;
        logic               lse_valid;
        logic signed [15:0] value_a;
        logic signed [15:0] value_b;
    } work_t;

    typedef logic [16:0] wtab_t [0:EXP_TABLE_DEPTH];

    // unsigned quotient by shift and subtract, for building the tables
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        int          i;
        q   = '0;
        rem = '0;
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-16k/depth) in q1.16 through exp(-y)^16
    function automatic logic [63:0] exp_rom(input logic [63:0] k);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        int          n;
        y    = (k << 30) / 64'(EXP_TABLE_DEPTH);
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        for (n = 1; n <= 24; n++)
        begin
            term = udiv64((term * y) >> 30, 64'(n));
            if (n[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        v = (sum < 0) ? 64'd0 : 64'(sum);
        if (v > ONE_Q30)
            v = ONE_Q30;
        for (n = 0; n < 4; n++)
            v = (v * v + (ONE_Q30 >> 1)) >> 30;
        return (v + 64'd8192) >> 14;
    endfunction

    // ln(1 + k/depth) in q16 through 2*atanh(u/(2+u))
    function automatic logic [63:0] log_rom(input logic [63:0] k);
        logic [63:0] u;
        logic [63:0] z;
        logic [63:0] p;
        logic [63:0] sum;
        int          n;
        u   = (k << 30) / 64'(LOG_TABLE_DEPTH);
        z   = udiv64(u << 30, 64'd2 * ONE_Q30 + u);
        p   = z;
        sum = z;
        for (n = 3; n <= 41; n += 2)
        begin
            p   = (p * z) >> 30;
            p   = (p * z) >> 30;
            sum = sum + udiv64(p, 64'(n));
        end
        return (64'd2 * sum + 64'd8192) >> 14;
    endfunction

    // small weight by distance code; last code means weight zero
    function automatic wtab_t build_weight_tab();
        wtab_t t;
        int    k;
        for (k = 0; k < EXP_TABLE_DEPTH; k++)
            t[k] = 17'(exp_rom(64'(k)));
        t[EXP_TABLE_DEPTH] = '0;
        return t;
    endfunction

    // rounded 2^32 / (1 + small weight) by distance code
    function automatic wtab_t build_inverse_tab();
        wtab_t       t;
        wtab_t       w;
        logic [63:0] s;
        int          k;
        w = build_weight_tab();
        for (k = 0; k <= EXP_TABLE_DEPTH; k++)
        begin
            s    = 64'(ONE_Q16) + 64'(w[k]);
            t[k] = 17'(udiv64((64'd1 << 32) + (s >> 1), s));
        end
        return t;
    endfunction

    // ln of weight sum by distance code
    function automatic wtab_t build_log_tab();
        wtab_t       t;
        wtab_t       w;
        logic [63:0] idx;
        int          k;
        w = build_weight_tab();
        for (k = 0; k <= EXP_TABLE_DEPTH; k++)
        begin
            idx = (64'(w[k]) * 64'(LOG_TABLE_DEPTH) + 64'd32768) >> 16;
            if (idx > 64'(LOG_TABLE_DEPTH))
                idx = 64'(LOG_TABLE_DEPTH);
            t[k] = 17'(log_rom(idx));
        end
        return t;
    endfunction

    localparam wtab_t WEIGHT_TAB  = build_weight_tab();
    localparam wtab_t INVERSE_TAB = build_inverse_tab();
    localparam wtab_t LOG_TAB     = build_log_tab();

endpackage

/* rtl/alm_front.sv */
// alm_front: accepts beats, derives per-position weights and lse, tags each element
`timescale 1ns / 1ps

module alm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  alm_pkg::item_t      src_data,
    output logic                push_valid,
    input  logic                push_stall,
    output alm_pkg::work_t      push_data
);

    localparam int IDX_W = 25 + $clog2(alm_pkg::EXP_TABLE_DEPTH + 1);

    logic                         s1_valid_reg;
    logic                         s1_first_reg;
    logic                         s1_age_reg;
    logic [alm_pkg::CODE_W-1:0]   s1_code_reg;
    logic signed [23:0]           s1_max_reg;
    logic signed [15:0]           s1_va_reg;
    logic signed [15:0]           s1_vb_reg;

    logic                         s2_valid_reg;
    alm_pkg::work_t               s2_reg;
    alm_pkg::work_t               s2_next;

    logic [16:0]                  weight_a_reg;
    logic [16:0]                  weight_b_reg;
    logic [16:0]                  inverse_sum_reg;

    logic                         s2_ready;
    logic                         s1_ready;
    logic                         load_s1;
    logic                         load_s2;

    logic                         a_ge_b;
    logic [24:0]                  diff;
    logic [IDX_W-1:0]             idx;
    logic [alm_pkg::CODE_W-1:0]   code;
    logic [16:0]                  small_w;
    logic signed [25:0]           lse_sum;

    // ready chain through both stages
    assign s2_ready  = !s2_valid_reg || !push_stall;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign src_stall = !s1_ready;
    assign load_s1   = src_valid && s1_ready;
    assign load_s2   = s1_valid_reg && s2_ready;

    // distance between the two lse values and its table code
    always_comb
    begin
        a_ge_b = src_data.lse_a >= src_data.lse_b;
        if (a_ge_b)
            diff = 25'(25'(signed'(src_data.lse_a)) - 25'(signed'(src_data.lse_b)));
        else
            diff = 25'(25'(signed'(src_data.lse_b)) - 25'(signed'(src_data.lse_a)));
        idx = IDX_W'((IDX_W'(diff) * IDX_W'(alm_pkg::EXP_TABLE_DEPTH)
              + (IDX_W'(1) << 19)) >> 20);
        if (idx >= IDX_W'(alm_pkg::EXP_TABLE_DEPTH))
            code = alm_pkg::CODE_W'(alm_pkg::EXP_TABLE_DEPTH);
        else
            code = idx[alm_pkg::CODE_W-1:0];
    end

    // weights, reciprocal and merged lse for the element entering stage two
    always_comb
    begin
        small_w = alm_pkg::WEIGHT_TAB[s1_code_reg];
        lse_sum = 26'(s1_max_reg) + 26'(alm_pkg::LOG_TAB[s1_code_reg]);
        s2_next.value_a   = s1_va_reg;
        s2_next.value_b   = s1_vb_reg;
        s2_next.lse_valid = s1_first_reg;
        if (s1_first_reg)
        begin
            s2_next.weight_a    = s1_age_reg ? alm_pkg::ONE_Q16 : small_w;
            s2_next.weight_b    = s1_age_reg ? small_w : alm_pkg::ONE_Q16;
            s2_next.inverse_sum = alm_pkg::INVERSE_TAB[s1_code_reg];
            if (lse_sum > 26'sd8388607)
                s2_next.merged_lse = 24'sd8388607;
            else
                s2_next.merged_lse = lse_sum[23:0];
        end
        else
        begin
            s2_next.weight_a    = weight_a_reg;
            s2_next.weight_b    = weight_b_reg;
            s2_next.inverse_sum = inverse_sum_reg;
            s2_next.merged_lse  = '0;
        end
    end

    // control and held weights
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            weight_a_reg    <= '0;
            weight_b_reg    <= '0;
            inverse_sum_reg <= '0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= src_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (load_s2)
            begin
                weight_a_reg    <= s2_next.weight_a;
                weight_b_reg    <= s2_next.weight_b;
                inverse_sum_reg <= s2_next.inverse_sum;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_first_reg <= src_data.first_of_position;
            s1_age_reg   <= a_ge_b;
            s1_code_reg  <= code;
            s1_max_reg   <= a_ge_b ? src_data.lse_a : src_data.lse_b;
            s1_va_reg    <= src_data.value_a;
            s1_vb_reg    <= src_data.value_b;
        end
        if (load_s2)
            s2_reg <= s2_next;
    end

    assign push_valid = s2_valid_reg;
    assign push_data  = s2_reg;

`ifndef SYNTHESIS
    // a new position always gives the larger lse full weight
    assert property (@(posedge clk) disable iff (!rst_n)
        (load_s2 && s1_first_reg) |=>
            (weight_a_reg == alm_pkg::ONE_Q16 || weight_b_reg == alm_pkg::ONE_Q16))
        else $error("no unit weight after new position");

    // reciprocal is zero exactly while no weights are held
    assert property (@(posedge clk) disable iff (!rst_n)
        ((weight_a_reg == '0 && weight_b_reg == '0) == (inverse_sum_reg == '0)))
        else $error("reciprocal out of step with weights");
`endif

endmodule

/* rtl/alm_queue.sv */
// alm_queue: short queue of classified elements between front and back
`timescale 1ns / 1ps

module alm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_stall,
    input  alm_pkg::work_t      push_data,
    output logic                pop_valid,
    input  logic                pop_stall,
    output alm_pkg::work_t      pop_data
);

    localparam int PTR_W = $clog2(alm_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(alm_pkg::QUEUE_DEPTH + 1);

    alm_pkg::work_t   mem [0:alm_pkg::QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_stall = count_reg == CNT_W'(alm_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;
    assign pop_data   = mem[rd_ptr_reg];

    // pointer wrap
    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PTR_W'(alm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_W'(alm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    // fill count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(alm_pkg::QUEUE_DEPTH))
        else $error("queue overfilled");
`endif

endmodule

/* rtl/alm_back.sv */
// alm_back: weighted average of the element pair, rounded and saturated
`timescale 1ns / 1ps

module alm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_stall,
    input  alm_pkg::work_t      pop_data,
    output logic                res_valid,
    input  logic                res_stall,
    output alm_pkg::result_t    res_data
);

    logic                b1_valid_reg;
    logic signed [34:0]  b1_sum_reg;
    logic [16:0]         b1_inv_reg;
    logic signed [23:0]  b1_lse_reg;
    logic                b1_lv_reg;

    logic                b2_valid_reg;
    logic signed [34:0]  b2_hi_reg;
    logic [34:0]         b2_lo_reg;
    logic signed [23:0]  b2_lse_reg;
    logic                b2_lv_reg;

    logic                b3_valid_reg;
    alm_pkg::result_t    b3_reg;
    alm_pkg::result_t    b3_next;

    logic                b1_ready;
    logic                b2_ready;
    logic                b3_ready;

    logic signed [33:0]  prod_a;
    logic signed [33:0]  prod_b;
    logic signed [34:0]  prod_hi;
    logic [34:0]         prod_lo;
    logic signed [53:0]  full_p;
    logic [53:0]         mag;
    logic [21:0]         rmag;

    assign b3_ready  = !b3_valid_reg || !res_stall;
    assign b2_ready  = !b2_valid_reg || b3_ready;
    assign b1_ready  = !b1_valid_reg || b2_ready;
    assign pop_stall = !b1_ready;

    // weight each value
    always_comb
    begin
        prod_a = $signed({1'b0, pop_data.weight_a}) * pop_data.value_a;
        prod_b = $signed({1'b0, pop_data.weight_b}) * pop_data.value_b;
    end

    // scale by reciprocal, split in upper and lower parts
    always_comb
    begin
        prod_hi = $signed(b1_sum_reg[34:18]) * $signed({1'b0, b1_inv_reg});
        prod_lo = 35'(b1_sum_reg[17:0]) * 35'(b1_inv_reg);
    end

    // recombine, round half away from zero, saturate
    always_comb
    begin
        full_p = (54'(b2_hi_reg) <<< 18) + $signed({19'b0, b2_lo_reg});
        mag    = full_p[53] ? 54'(-full_p) : 54'(full_p);
        rmag   = 22'((mag + (54'd1 << 31)) >> 32);
        if (full_p[53])
            b3_next.merged_value = (rmag > 22'd32768) ? 16'sh8000 : 16'(-rmag);
        else
            b3_next.merged_value = (rmag > 22'd32767) ? 16'sh7fff : rmag[15:0];
        b3_next.merged_lse = b2_lse_reg;
        b3_next.lse_valid  = b2_lv_reg;
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_ready)
                b1_valid_reg <= pop_valid;
            if (b2_ready)
                b2_valid_reg <= b1_valid_reg;
            if (b3_ready)
                b3_valid_reg <= b2_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (pop_valid && b1_ready)
        begin
            b1_sum_reg <= 35'(prod_a) + 35'(prod_b);
            b1_inv_reg <= pop_data.inverse_sum;
            b1_lse_reg <= pop_data.merged_lse;
            b1_lv_reg  <= pop_data.lse_valid;
        end
        if (b1_valid_reg && b2_ready)
        begin
            b2_hi_reg  <= prod_hi;
            b2_lo_reg  <= prod_lo;
            b2_lse_reg <= b1_lse_reg;
            b2_lv_reg  <= b1_lv_reg;
        end
        if (b2_valid_reg && b3_ready)
            b3_reg <= b3_next;
    end

    assign res_valid = b3_valid_reg;
    assign res_data  = b3_reg;

endmodule

/* rtl/attention_lse_merge.sv */
// attention_lse_merge: merges two partial attention outputs by their log-sum-exp
//
//   channel  direction  payload            handshake
//   src      in         alm_pkg::item_t    src_valid / src_stall
//   res      out        alm_pkg::result_t  res_valid / res_stall
//
// one beat in and one beat out per cycle when neither side stalls
// the path from input accept to result runs through
// two front stages, one queue slot, three back stages
// weights come from constant tables
// reset clears all valids and the held weights, so elements before a position give zero
// a stall on res fills the queue before src sees a stall
`timescale 1ns / 1ps

module attention_lse_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  alm_pkg::item_t      src_data,
    output logic                res_valid,
    input  logic                res_stall,
    output alm_pkg::result_t    res_data
);

    logic            push_valid;
    logic            push_stall;
    alm_pkg::work_t  push_data;
    logic            pop_valid;
    logic            pop_stall;
    alm_pkg::work_t  pop_data;

    // classify and tag with weights
    alm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_data   (src_data),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_data  (push_data)
    );

    // decoupling queue
    alm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_stall (push_stall),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_stall  (pop_stall),
        .pop_data   (pop_data)
    );

    // weighted average
    alm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_stall  (pop_stall),
        .pop_data   (pop_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

`ifndef SYNTHESIS
    // lse field is zero on beats that start no position
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_data.lse_valid) |-> (res_data.merged_lse == '0))
        else $error("merged lse on continuation beat");
`endif

endmodule
